FILE: hdl/fsv_pkg.sv
// Shared types, codes and the base lookup for the FASTA stream validator.
// No dependencies; used by fsv_step, fsv_out_buf, fasta_stream_validator and tb.
package fsv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 3;

  localparam logic [ByteW-1:0] ChNewline = 8'd10;
  localparam logic [ByteW-1:0] ChGt      = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] ChA       = 8'h41;
  localparam logic [ByteW-1:0] ChC       = 8'h43;
  localparam logic [ByteW-1:0] ChG       = 8'h47;
  localparam logic [ByteW-1:0] ChN       = 8'h4E;
  localparam logic [ByteW-1:0] ChT       = 8'h54;
  localparam logic [ByteW-1:0] ChLowA    = 8'h61;
  localparam logic [ByteW-1:0] ChLowZ    = 8'h7A;
  localparam logic [ByteW-1:0] CaseGap   = 8'd32;

  typedef enum logic [2:0] {
    KIND_NONE = 3'b001,
    KIND_NAME = 3'b010,
    KIND_BASE = 3'b100
  } line_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_EMPTY_NAME    = 3'd1,
    ERR_NAME_NO_BASES = 3'd2,
    ERR_NO_NAME       = 3'd3,
    ERR_BAD_BASE      = 3'd4,
    ERR_INCOMPLETE    = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    BASE_A = 3'd0,
    BASE_C = 3'd1,
    BASE_G = 3'd2,
    BASE_T = 3'd3,
    BASE_N = 3'd4
  } base_e;

  typedef struct packed {
    line_kind_e line_kind;
    logic       name_has_chars;
    logic       have_name;
    logic       have_bases;
    err_e       failed_code;
  } fsv_state_t;

  typedef struct packed {
    logic             base_valid;
    logic [CodeW-1:0] base_code;
    logic             name_valid;
    logic [ByteW-1:0] name_byte;
    logic             record_start;
    logic             record_end;
    err_e             error_kind;
    logic             done_res;
  } fsv_res_t;

  localparam fsv_state_t StateReset = '{
    line_kind:      KIND_NONE,
    name_has_chars: 1'b0,
    have_name:      1'b0,
    have_bases:     1'b0,
    failed_code:    ERR_NONE
  };

  // Upper-case a..z, then map A C G T N; bit 3 set means a valid base.
  function automatic logic [CodeW:0] base_lookup(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    logic [CodeW:0]   r;
    c = b;
    if (b >= ChLowA && b <= ChLowZ) begin
      c = b - CaseGap;
    end
    case (c)
      ChA:     r = {1'b1, BASE_A};
      ChC:     r = {1'b1, BASE_C};
      ChG:     r = {1'b1, BASE_G};
      ChT:     r = {1'b1, BASE_T};
      ChN:     r = {1'b1, BASE_N};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/fsv_step.sv
// Per-byte parse step: next parser state and the result for one request.
// Depends on fsv_pkg.
module fsv_step (
  input  fsv_pkg::fsv_state_t        state_i,
  input  logic [fsv_pkg::ByteW-1:0]  byte_i,
  input  logic                       end_i,
  output fsv_pkg::fsv_state_t        state_o,
  output fsv_pkg::fsv_res_t          res_o
);

  logic [fsv_pkg::CodeW:0] lookup;
  logic                    is_nl;

  assign lookup = fsv_pkg::base_lookup(byte_i);
  assign is_nl  = (byte_i == fsv_pkg::ChNewline);

  always_comb begin
    state_o = state_i;
    res_o   = '0;

    if (end_i) begin
      if (state_i.failed_code == fsv_pkg::ERR_NONE) begin
        if (state_i.line_kind == fsv_pkg::KIND_NAME && !state_i.name_has_chars) begin
          state_o.failed_code = fsv_pkg::ERR_EMPTY_NAME;
        end else if (!state_i.have_name || !state_i.have_bases) begin
          state_o.failed_code = fsv_pkg::ERR_INCOMPLETE;
        end else begin
          res_o.record_end = 1'b1;
        end
      end
      res_o.error_kind = state_o.failed_code;
      res_o.done_res   = 1'b1;
      state_o          = fsv_pkg::StateReset;
    end else if (state_i.failed_code != fsv_pkg::ERR_NONE) begin
      res_o.error_kind = state_i.failed_code;
    end else begin
      case (state_i.line_kind)
        fsv_pkg::KIND_NAME: begin
          if (is_nl) begin
            if (!state_i.name_has_chars) begin
              state_o.failed_code = fsv_pkg::ERR_EMPTY_NAME;
            end
            state_o.line_kind = fsv_pkg::KIND_NONE;
          end else if (!state_i.name_has_chars && state_i.have_name
                       && !state_i.have_bases) begin
            state_o.failed_code = fsv_pkg::ERR_NAME_NO_BASES;
          end else begin
            if (!state_i.name_has_chars) begin
              res_o.record_end       = state_i.have_bases;
              state_o.have_bases     = 1'b0;
              state_o.have_name      = 1'b1;
              state_o.name_has_chars = 1'b1;
            end
            res_o.name_valid = 1'b1;
            res_o.name_byte  = byte_i;
          end
        end
        fsv_pkg::KIND_BASE: begin
          if (is_nl) begin
            state_o.line_kind = fsv_pkg::KIND_NONE;
          end else if (lookup[fsv_pkg::CodeW]) begin
            res_o.base_valid   = 1'b1;
            res_o.base_code    = lookup[fsv_pkg::CodeW-1:0];
            state_o.have_bases = 1'b1;
          end else begin
            state_o.failed_code = fsv_pkg::ERR_BAD_BASE;
          end
        end
        default: begin
          // No line open: the first byte decides the line kind.
          if (is_nl) begin
            if (!state_i.have_name) begin
              state_o.failed_code = fsv_pkg::ERR_NO_NAME;
            end
            state_o.line_kind = fsv_pkg::KIND_NONE;
          end else if (byte_i == fsv_pkg::ChGt) begin
            state_o.line_kind      = fsv_pkg::KIND_NAME;
            state_o.name_has_chars = 1'b0;
            res_o.record_start     = 1'b1;
          end else begin
            state_o.line_kind = fsv_pkg::KIND_BASE;
            if (!state_i.have_name) begin
              state_o.failed_code = fsv_pkg::ERR_NO_NAME;
            end else if (lookup[fsv_pkg::CodeW]) begin
              res_o.base_valid   = 1'b1;
              res_o.base_code    = lookup[fsv_pkg::CodeW-1:0];
              state_o.have_bases = 1'b1;
            end else begin
              state_o.failed_code = fsv_pkg::ERR_BAD_BASE;
            end
          end
        end
      endcase
      res_o.error_kind = state_o.failed_code;
    end
  end

endmodule

FILE: hdl/fsv_out_buf.sv
// Two-entry result buffer (output register plus skid register).
// Depends on fsv_pkg for the result type.
module fsv_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fsv_pkg::fsv_res_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fsv_pkg::fsv_res_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  fsv_pkg::fsv_res_t out_q, out_d;
  fsv_pkg::fsv_res_t skid_q, skid_d;
  logic              in_fire;
  logic              out_free;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // Drain the skid entry; the input is stalled this cycle.
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = in_data_i;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_skid_waits_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && !skid_valid_q && in_valid_i) |=> skid_valid_q)
    else $error("request lost while output stalled");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

FILE: hdl/fasta_stream_validator.sv
// FASTA stream validator top level: parser state register and result buffer.
// Depends on fsv_pkg, fsv_step and fsv_out_buf.
//
// Feed the FASTA text one byte per request on the slave stream, and close the
// text with a request that has tlast set (its data byte is ignored). Every
// request gives exactly one result on the master stream, in order. The block
// takes one byte per clock while input ready is high: the whole parse of a
// byte is a few flag updates that finish in the single parser state register,
// and a two-entry result buffer keeps the input flowing while the output
// stalls, so input ready only drops once two results are waiting.
// Results carry base codes (A C G T N as 0..4) for base lines, name bytes for
// the rest of a '>' line, record start/end marks, and a sticky error code; once
// an error is raised, results carry only the error until the end request, whose
// result has tlast set and after which the parser returns to its reset state.
module fasta_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] base_valid, [3:1] base_code,
                                      // [4] name_valid, [12:5] name_byte,
                                      // [13] record_start, [14] record_end,
                                      // [17:15] error_kind, [23:18] zero
  output logic        m_axis_tlast    // done_res
);

  fsv_pkg::fsv_state_t state_q, state_d;
  fsv_pkg::fsv_res_t   step_res;
  fsv_pkg::fsv_res_t   out_res;
  logic                s_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Next state and result for the byte at the input.
  fsv_step u_step (
    .state_i (state_q),
    .byte_i  (s_axis_tdata),
    .end_i   (s_axis_tlast),
    .state_o (state_d),
    .res_o   (step_res)
  );

  // Advance the parser only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsv_pkg::StateReset;
    end else if (s_fire) begin
      state_q <= state_d;
    end
  end

  fsv_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (step_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Pack result fields from the lowest bit up, zero-fill to whole bytes.
  assign m_axis_tdata = {6'b0, out_res.error_kind, out_res.record_end,
                         out_res.record_start, out_res.name_byte,
                         out_res.name_valid, out_res.base_code,
                         out_res.base_valid};
  assign m_axis_tlast = out_res.done_res;

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !s_axis_tlast && state_q.failed_code != fsv_pkg::ERR_NONE)
      |=> $stable(state_q))
    else $error("parser state moved after an error");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> (state_q == fsv_pkg::StateReset))
    else $error("parser not back in reset state after end request");

  a_error_clears_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.error_kind != fsv_pkg::ERR_NONE)
      |-> (!out_res.base_valid && !out_res.name_valid && !out_res.record_start
           && !out_res.record_end))
    else $error("data flags set on an error result");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({out_res.base_valid, out_res.name_valid,
                                out_res.record_start, out_res.done_res}))
    else $error("result marks more than one kind of byte");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for fasta_stream_validator: directed FASTA texts, then random texts.
// Depends on fsv_pkg for the line kind, error and base codes and the character constants.
module tb;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned TailCycles = 8;

  // One result as it leaves the master stream.
  typedef struct packed {
    logic                     base_valid;
    fsv_pkg::base_e           base_code;
    logic                     name_valid;
    logic [fsv_pkg::ByteW-1:0] name_byte;
    logic                     record_start;
    logic                     record_end;
    fsv_pkg::err_e            error_kind;
    logic                     done_res;
  } parse_res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Parser state as the predictor sees it.
  fsv_pkg::line_kind_e kind;
  logic                name_started;
  logic                have_name;
  logic                have_bases;
  fsv_pkg::err_e       fail_code;

  parse_res_t  parse_results_q[$];
  int unsigned fail_cnt       = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;

  fasta_stream_validator dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_parse_state();
    kind         = fsv_pkg::KIND_NONE;
    name_started = 1'b0;
    have_name    = 1'b0;
    have_bases   = 1'b0;
    fail_code    = fsv_pkg::ERR_NONE;
  endfunction

  // First error wins; later ones are dropped.
  function automatic void flag_error(input fsv_pkg::err_e code);
    if (fail_code == fsv_pkg::ERR_NONE) begin
      fail_code = code;
    end
  endfunction

  // Upper-case a..z and map A C G T N; anything else on a base line is a bad base.
  function automatic void decode_base(input logic [7:0] b, inout parse_res_t r);
    logic [7:0] up;
    up = b;
    if (b >= fsv_pkg::ChLowA && b <= fsv_pkg::ChLowZ) begin
      up = b - fsv_pkg::CaseGap;
    end
    r.base_valid = 1'b1;
    case (up)
      fsv_pkg::ChA: r.base_code = fsv_pkg::BASE_A;
      fsv_pkg::ChC: r.base_code = fsv_pkg::BASE_C;
      fsv_pkg::ChG: r.base_code = fsv_pkg::BASE_G;
      fsv_pkg::ChT: r.base_code = fsv_pkg::BASE_T;
      fsv_pkg::ChN: r.base_code = fsv_pkg::BASE_N;
      default: begin
        r.base_valid = 1'b0;
        flag_error(fsv_pkg::ERR_BAD_BASE);
      end
    endcase
    if (r.base_valid) begin
      have_bases = 1'b1;
    end
  endfunction

  // Advance the predicted parser by one request and queue the result it gives.
  function automatic void parse_byte(input logic [7:0] b, input logic is_end);
    parse_res_t r;
    r = '0;
    if (is_end) begin
      if (fail_code == fsv_pkg::ERR_NONE) begin
        if (kind == fsv_pkg::KIND_NAME && !name_started) begin
          flag_error(fsv_pkg::ERR_EMPTY_NAME);
        end else if (!have_name || !have_bases) begin
          flag_error(fsv_pkg::ERR_INCOMPLETE);
        end else begin
          r.record_end = 1'b1;
        end
      end
      r.error_kind = fail_code;
      r.done_res   = 1'b1;
      clear_parse_state();
    end else if (fail_code != fsv_pkg::ERR_NONE) begin
      r.error_kind = fail_code;
    end else begin
      case (kind)
        fsv_pkg::KIND_NAME: begin
          if (b == fsv_pkg::ChNewline) begin
            if (!name_started) begin
              flag_error(fsv_pkg::ERR_EMPTY_NAME);
            end
            kind = fsv_pkg::KIND_NONE;
          end else begin
            // The first name byte closes the previous record.
            if (!name_started) begin
              if (have_name && !have_bases) begin
                flag_error(fsv_pkg::ERR_NAME_NO_BASES);
              end else begin
                r.record_end = have_bases;
                have_bases   = 1'b0;
                have_name    = 1'b1;
                name_started = 1'b1;
              end
            end
            if (fail_code == fsv_pkg::ERR_NONE) begin
              r.name_valid = 1'b1;
              r.name_byte  = b;
            end
          end
        end
        fsv_pkg::KIND_BASE: begin
          if (b == fsv_pkg::ChNewline) begin
            kind = fsv_pkg::KIND_NONE;
          end else begin
            decode_base(b, r);
          end
        end
        default: begin
          if (b == fsv_pkg::ChNewline) begin
            if (!have_name) begin
              flag_error(fsv_pkg::ERR_NO_NAME);
            end
            kind = fsv_pkg::KIND_NONE;
          end else if (b == fsv_pkg::ChGt) begin
            kind           = fsv_pkg::KIND_NAME;
            name_started   = 1'b0;
            r.record_start = 1'b1;
          end else begin
            kind = fsv_pkg::KIND_BASE;
            if (!have_name) begin
              flag_error(fsv_pkg::ERR_NO_NAME);
            end else begin
              decode_base(b, r);
            end
          end
        end
      endcase
      r.error_kind = fail_code;
    end
    parse_results_q = {parse_results_q, r};
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      fail_cnt++;
    end
  endfunction

  // Check each accepted result against the oldest prediction, then pick the next ready.
  always @(posedge clk_i) begin
    parse_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parse_results_q.size() == 0) begin
        $error("result with no request pending: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        fail_cnt++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("base_valid", want.base_valid, m_axis_tdata[0]);
        check_field("base_code", want.base_code, m_axis_tdata[3:1]);
        check_field("name_valid", want.name_valid, m_axis_tdata[4]);
        check_field("name_byte", want.name_byte, m_axis_tdata[12:5]);
        check_field("record_start", want.record_start, m_axis_tdata[13]);
        check_field("record_end", want.record_end, m_axis_tdata[14]);
        check_field("error_kind", want.error_kind, m_axis_tdata[17:15]);
        check_field("done_res", want.done_res, m_axis_tlast);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Send one request, with a random gap first; predict its result once accepted.
  task automatic send_req(input logic [7:0] b, input logic is_end);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_gap_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b, is_end);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_req(s[i], 1'b0);
    end
  endtask

  task automatic send_end(input logic [7:0] b);
    send_req(b, 1'b1);
  endtask

  // Hold off the input until every predicted result has come out.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a valid base letter in either case; rarely any byte at all.
  function automatic logic [7:0] pick_base();
    logic [7:0] b;
    if ($urandom_range(99) == 0) begin
      return 8'($urandom_range(255));
    end
    case ($urandom_range(4))
      0:       b = fsv_pkg::ChA;
      1:       b = fsv_pkg::ChC;
      2:       b = fsv_pkg::ChG;
      3:       b = fsv_pkg::ChT;
      default: b = fsv_pkg::ChN;
    endcase
    if ($urandom_range(1) == 1) begin
      b = b + fsv_pkg::CaseGap;
    end
    return b;
  endfunction

  // One whole text: mostly well-formed records, sometimes broken ones or plain noise.
  task automatic send_random_text();
    int unsigned n_rec;
    int unsigned n_lines;
    int unsigned len;
    logic [7:0]  b;
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 8)) send_req(8'($urandom_range(255)), 1'b0);
    end else begin
      if ($urandom_range(99) < 2) begin
        send_req(fsv_pkg::ChNewline, 1'b0);
      end
      n_rec = $urandom_range(1, 3);
      repeat (n_rec) begin
        send_req(fsv_pkg::ChGt, 1'b0);
        len = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 6);
        repeat (len) begin
          do b = 8'($urandom_range(255)); while (b == fsv_pkg::ChNewline);
          send_req(b, 1'b0);
        end
        send_req(fsv_pkg::ChNewline, 1'b0);
        n_lines = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 3);
        repeat (n_lines) begin
          repeat ($urandom_range(0, 10)) send_req(pick_base(), 1'b0);
          if ($urandom_range(9) != 0) begin
            send_req(fsv_pkg::ChNewline, 1'b0);
          end
        end
      end
    end
    send_end(8'($urandom_range(255)));
  endtask

  // Two records, all five bases in mixed case, name bytes at both extremes.
  task automatic test_clean_records();
    send_str(">");
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    send_str("\nAcgTn\n\n>q\nN\n");
    send_end(8'hFF);
  endtask

  // Empty name closed by newline or by the end, and a name that got no bases.
  task automatic test_name_errors();
    send_str(">\n");
    send_end(8'h00);
    send_str(">");
    send_end(8'h00);
    send_str(">a\n>bc\nAC");
    send_end(8'h00);
  endtask

  // Empty line or base byte before any name.
  task automatic test_no_name();
    send_str("\n");
    send_end(8'h00);
    send_str("g");
    send_end(8'h00);
  endtask

  // Carriage return and a high byte on base lines.
  task automatic test_bad_base();
    send_str(">a\nAC\r");
    send_end(8'h00);
    send_str(">a\nG");
    send_req(8'h80, 1'b0);
    send_end(8'h00);
  endtask

  // End with nothing at all, and with a name but no bases.
  task automatic test_incomplete_end();
    send_end(8'h00);
    send_str(">a\n");
    send_end(8'h00);
  endtask

  task automatic test_random_texts(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_text();
    hold_until_drained();
  endtask

  initial begin
    clear_parse_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_gap_pct    = 16;
    sink_stall_pct = 49;
    test_clean_records();
    test_name_errors();
    test_no_name();
    test_bad_base();
    test_incomplete_end();
    hold_until_drained();
    test_random_texts(170);

    src_gap_pct    = 49;
    sink_stall_pct = 16;
    test_random_texts(170);

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_texts(170);

    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_cnt == 0 && parse_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fsv_pkg.sv
hdl/fsv_step.sv
hdl/fsv_out_buf.sv
hdl/fasta_stream_validator.sv
bench/tb.sv
